[rtl/core/sorted_six_combination_enumerator_unit_assert.svh]
// Assertion macros shared by the enumerator RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef SORTED_SIX_COMBINATION_ENUMERATOR_UNIT_ASSERT_SVH
`define SORTED_SIX_COMBINATION_ENUMERATOR_UNIT_ASSERT_SVH

// The condition holds at every clock edge.
`define SSCE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SSCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SSCE_ASSERT_IMPLY_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ssce_pkg.sv]
package ssce_pkg;

    localparam int MAX_SET = 16;
    localparam int PICKS   = 6;
    localparam int VAL_W   = 8;
    localparam int IDX_W   = $clog2(MAX_SET);
    localparam int CNT_W   = $clog2(MAX_SET + 1);
    localparam int SEL_W   = $clog2(PICKS);

    typedef logic [VAL_W-1:0] value_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [SEL_W-1:0] sel_t;
    typedef value_t [MAX_SET-1:0] store_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_NEXT  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_DONE = 2'd2,
        ST_OVF  = 2'd3
    } status_t;

    typedef struct packed {
        logic   clear;
        logic   load;
        value_t value;
    } store_ctrl_t;

    typedef struct packed {
        count_t count;
        logic   full;
        logic   overflow;
    } store_stat_t;

    typedef struct packed {
        logic clear;
        logic restart;
        logic step;
    } pick_ctrl_t;

    typedef struct packed {
        value_t [PICKS-1:0] picks;
        logic               final_one;
        status_t            status;
    } result_t;

endpackage

[rtl/core/ssce_req_if.sv]
interface ssce_req_if;

    logic            valid;
    logic            ready;
    logic [1:0]      command;
    ssce_pkg::value_t value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);

endinterface

[rtl/core/ssce_res_if.sv]
interface ssce_res_if;

    logic             valid;
    logic             ready;
    ssce_pkg::value_t pick_a;
    ssce_pkg::value_t pick_b;
    ssce_pkg::value_t pick_c;
    ssce_pkg::value_t pick_d;
    ssce_pkg::value_t pick_e;
    ssce_pkg::value_t pick_f;
    logic             final_one;
    logic [1:0]       status;

    modport source (
        output valid, output pick_a, output pick_b, output pick_c, output pick_d,
        output pick_e, output pick_f, output final_one, output status, input ready
    );
    modport sink (
        input valid, input pick_a, input pick_b, input pick_c, input pick_d,
        input pick_e, input pick_f, input final_one, input status, output ready
    );

endinterface

[rtl/core/ssce_store.sv]
module ssce_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssce_pkg::store_ctrl_t  ctrl,
    output ssce_pkg::store_t       store,
    output ssce_pkg::store_stat_t  stat
);

    ssce_pkg::store_t  store_reg;
    ssce_pkg::store_t  store_next;
    ssce_pkg::count_t  count_reg;
    ssce_pkg::count_t  count_next;
    logic              overflow_reg;
    logic              overflow_next;
    logic              full;
    logic [ssce_pkg::MAX_SET-1:0] keep;
    ssce_pkg::store_t  inserted;

    assign full = (count_reg == ssce_pkg::CNT_W'(ssce_pkg::MAX_SET));

    // The store is sorted, so each entry either keeps its value, takes the new
    // value, or takes its lower neighbor.
    always_comb
    begin
        for (int i = 0; i < ssce_pkg::MAX_SET; i++)
        begin
            keep[i] = (ssce_pkg::CNT_W'(i) < count_reg) && (store_reg[i] <= ctrl.value);
        end
        for (int i = 0; i < ssce_pkg::MAX_SET; i++)
        begin
            if (keep[i])
            begin
                inserted[i] = store_reg[i];
            end
            else if (i == 0)
            begin
                inserted[i] = ctrl.value;
            end
            else if (keep[i-1])
            begin
                inserted[i] = ctrl.value;
            end
            else
            begin
                inserted[i] = store_reg[i-1];
            end
        end
    end

    always_comb
    begin
        store_next    = store_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (ctrl.clear)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                store_next = inserted;
                count_next = count_reg + ssce_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    assign store         = store_reg;
    assign stat.count    = count_reg;
    assign stat.full     = full;
    assign stat.overflow = overflow_reg;

endmodule

[rtl/core/ssce_pick.sv]
module ssce_pick (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssce_pkg::pick_ctrl_t   ctrl,
    input  ssce_pkg::store_t       store,
    input  ssce_pkg::store_stat_t  stat,
    output ssce_pkg::result_t      result
);

    localparam int CMP_W = ssce_pkg::CNT_W + 1;

    ssce_pkg::idx_t [ssce_pkg::PICKS-1:0] idx_reg;
    ssce_pkg::idx_t [ssce_pkg::PICKS-1:0] idx_next;
    ssce_pkg::idx_t [ssce_pkg::PICKS-1:0] eff;
    ssce_pkg::idx_t [ssce_pkg::PICKS-1:0] adv;
    logic                                 started_reg;
    logic                                 started_next;
    logic                                 done_reg;
    logic                                 done_next;
    logic [ssce_pkg::PICKS-1:0]           can;
    logic [CMP_W-1:0]                     limit;
    logic                                 found;
    ssce_pkg::sel_t                       sel;
    ssce_pkg::idx_t                       base;
    logic                                 few;
    logic                                 live;

    // Before the first word of an enumeration the picks are the lowest positions.
    always_comb
    begin
        for (int j = 0; j < ssce_pkg::PICKS; j++)
        begin
            eff[j] = started_reg ? idx_reg[j] : ssce_pkg::IDX_W'(j);
        end
    end

    // The rightmost pick that still has room moves up by one and the picks
    // to its right follow it in consecutive positions.
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        limit = '0;
        for (int k = 0; k < ssce_pkg::PICKS; k++)
        begin
            limit  = CMP_W'(stat.count) + CMP_W'(k) - CMP_W'(ssce_pkg::PICKS);
            can[k] = CMP_W'(eff[k]) < limit;
        end
        for (int k = 0; k < ssce_pkg::PICKS; k++)
        begin
            if (can[k])
            begin
                found = 1'b1;
                sel   = ssce_pkg::SEL_W'(k);
            end
        end
        base = eff[sel] + ssce_pkg::IDX_W'(1);
        for (int j = 0; j < ssce_pkg::PICKS; j++)
        begin
            if (ssce_pkg::SEL_W'(j) < sel)
            begin
                adv[j] = eff[j];
            end
            else
            begin
                adv[j] = base + ssce_pkg::IDX_W'(ssce_pkg::SEL_W'(j) - sel);
            end
        end
    end

    assign few  = (stat.count < ssce_pkg::CNT_W'(ssce_pkg::PICKS));
    assign live = !few && !done_reg;

    always_comb
    begin
        result.picks     = '0;
        result.final_one = 1'b0;
        result.status    = ssce_pkg::ST_OK;
        if (few)
        begin
            result.status = ssce_pkg::ST_FEW;
        end
        else if (done_reg)
        begin
            result.status = ssce_pkg::ST_DONE;
        end
        else
        begin
            for (int j = 0; j < ssce_pkg::PICKS; j++)
            begin
                result.picks[j] = store[eff[j]];
            end
            result.final_one = !found;
            result.status    = stat.overflow ? ssce_pkg::ST_OVF : ssce_pkg::ST_OK;
        end
    end

    always_comb
    begin
        idx_next     = idx_reg;
        started_next = started_reg;
        done_next    = done_reg;
        if (ctrl.clear)
        begin
            idx_next     = '0;
            started_next = 1'b0;
            done_next    = 1'b0;
        end
        else if (ctrl.restart)
        begin
            started_next = 1'b0;
            done_next    = 1'b0;
        end
        else if (ctrl.step && live)
        begin
            started_next = 1'b1;
            idx_next     = adv;
            done_next    = !found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            started_reg <= started_next;
            done_reg    <= done_next;
        end
    end

endmodule

[rtl/core/sorted_six_combination_enumerator_unit.sv]
// Sorted six-combination enumerator.
// The req channel carries command words: clear the set, load one value, or
// ask for the next six-element combination. Only a next request produces a
// word on res: six picks in ascending order, a final_one flag on the
// last combination of the set, and a status code (ok, too few values,
// enumeration exhausted, or ok with an overflow seen since the last clear).
// Loads beyond sixteen values are dropped and raise the overflow status.
// A command word is registered in the input register on acceptance and
// resolved there; a next request's result goes to the output register.
// One command word is taken every cycle unless a next request waits on a
// stalled res; the store update and the next-combination step are each one
// pass of compare-and-select logic.
// When res stalls, the result word holds in the output register; a pending next
// request then waits in the input register, and req.ready drops only while
// that register is occupied and cannot drain.
// Reset empties the set, clears all flags and leaves both channels idle.
`include "sorted_six_combination_enumerator_unit_assert.svh"

module sorted_six_combination_enumerator_unit (
    input  logic clk,
    input  logic rst_n,
    ssce_req_if.sink   req,
    ssce_res_if.source res
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    ssce_pkg::cmd_t        s1_cmd_reg;
    ssce_pkg::value_t      s1_value_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    ssce_pkg::result_t     res_reg;
    ssce_pkg::result_t     result;
    logic                  is_clear;
    logic                  is_load;
    logic                  is_next;
    logic                  out_free;
    logic                  s1_fire;
    ssce_pkg::store_ctrl_t sctl;
    ssce_pkg::store_stat_t stat;
    ssce_pkg::store_t      store;
    ssce_pkg::pick_ctrl_t  pctl;
    logic                  count_ok;
    logic                  set_empty;
    logic                  word_live;
    logic                  word_blank;
    logic                  picks_in_order;

    always_comb
    begin
        is_clear = 1'b0;
        is_load  = 1'b0;
        is_next  = 1'b0;
        case (s1_cmd_reg)
            ssce_pkg::CMD_CLEAR: is_clear = 1'b1;
            ssce_pkg::CMD_LOAD:  is_load  = 1'b1;
            ssce_pkg::CMD_NEXT:  is_next  = 1'b1;
            default:
            begin
                is_clear = 1'b0;
            end
        endcase
    end

    assign out_free  = !out_valid_reg || res.ready;
    assign s1_fire   = s1_valid_reg && (!is_next || out_free);
    assign req.ready = !s1_valid_reg || s1_fire;

    assign sctl.clear   = s1_fire && is_clear;
    assign sctl.load    = s1_fire && is_load;
    assign sctl.value   = s1_value_reg;
    assign pctl.clear   = sctl.clear;
    assign pctl.restart = sctl.load && !stat.full;
    assign pctl.step    = s1_fire && is_next;

    ssce_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sctl),
        .store (store),
        .stat  (stat)
    );

    ssce_pick u_pick (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (pctl),
        .store  (store),
        .stat   (stat),
        .result (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req.valid && req.ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (pctl.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_cmd_reg   <= ssce_pkg::cmd_t'(req.command);
            s1_value_reg <= req.value;
        end
        if (pctl.step)
        begin
            res_reg <= result;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.pick_a    = res_reg.picks[0];
    assign res.pick_b    = res_reg.picks[1];
    assign res.pick_c    = res_reg.picks[2];
    assign res.pick_d    = res_reg.picks[3];
    assign res.pick_e    = res_reg.picks[4];
    assign res.pick_f    = res_reg.picks[5];
    assign res.final_one = res_reg.final_one;
    assign res.status    = res_reg.status;

    assign count_ok   = (stat.count <= ssce_pkg::CNT_W'(ssce_pkg::MAX_SET));
    assign set_empty  = (stat.count == '0) && !stat.overflow;
    assign word_live  = out_valid_reg
                        && (res_reg.status == ssce_pkg::ST_OK
                            || res_reg.status == ssce_pkg::ST_OVF);
    assign word_blank = out_valid_reg
                        && (res_reg.status == ssce_pkg::ST_FEW
                            || res_reg.status == ssce_pkg::ST_DONE);
    assign picks_in_order = (res_reg.picks[0] <= res_reg.picks[1])
                            && (res_reg.picks[1] <= res_reg.picks[2])
                            && (res_reg.picks[2] <= res_reg.picks[3])
                            && (res_reg.picks[3] <= res_reg.picks[4])
                            && (res_reg.picks[4] <= res_reg.picks[5]);

    `SSCE_ASSERT_ALWAYS(a_count_bound, count_ok, "element count above capacity")
    `SSCE_ASSERT_IMPLY_NEXT(a_clear_empties, sctl.clear, set_empty, "clear left values behind")
    `SSCE_ASSERT_IMPLY(a_picks_sorted, word_live, picks_in_order, "combination word out of order")
    `SSCE_ASSERT_IMPLY(a_empty_word, word_blank, !res_reg.final_one && res_reg.picks == '0, "status word carries picks")

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    import ssce_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STIM_WORDS  = 2000;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [1:0] command;
        value_t     value;
    } cmd_word_t;

    logic clk;
    logic rst_n;

    ssce_req_if req_bus();
    ssce_res_if res_bus();

    sorted_six_combination_enumerator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus)
    );

    cmd_word_t command_words[$];
    result_t   pending_combos[$];

    value_t combo_store[MAX_SET];
    int     set_size;
    int     combo_pos[PICKS];
    bit     walk_started;
    bit     walk_done;
    bit     overflowed;

    int        fail_count;
    int        n_total;
    int        n_counted;
    int        n_taken;
    int        cycle_count;
    int        idle_cycles;
    int        req_wait;
    int        res_wait;
    bit        req_taken;
    bit        res_taken;
    cmd_word_t next_word;
    result_t   want;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Waits drop to zero for whole stretches so back-to-back traffic is also covered.
    function automatic int draw_wait();
        if ((cycle_count / 400) % 3 == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic value_t pick_value();
        case ($urandom_range(0, 3))
            0: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            1: return value_t'($urandom_range(100, 103));
            default: return value_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_word(input logic [1:0] command, input value_t value);
        cmd_word_t w;
        w.command = command;
        w.value   = value;
        command_words.push_back(w);
        n_total++;
        if (command != CMD_UNUSED)
            n_counted++;
    endtask

    task automatic apply_command(input logic [1:0] command, input value_t value);
        result_t r;
        int      pos;
        int      k;
        int      j;
        bit      moved;
        case (command)
            CMD_CLEAR:
            begin
                set_size = 0;
                for (k = 0; k < PICKS; k++)
                    combo_pos[k] = 0;
                walk_started = 1'b0;
                walk_done    = 1'b0;
                overflowed   = 1'b0;
            end
            CMD_LOAD:
            begin
                if (set_size >= MAX_SET)
                    overflowed = 1'b1;
                else
                begin
                    pos = set_size;
                    while (pos > 0 && combo_store[pos-1] > value)
                    begin
                        combo_store[pos] = combo_store[pos-1];
                        pos--;
                    end
                    combo_store[pos] = value;
                    set_size++;
                    walk_started = 1'b0;
                    walk_done    = 1'b0;
                end
            end
            CMD_NEXT:
            begin
                r = '0;
                if (set_size < PICKS)
                    r.status = ST_FEW;
                else if (walk_done)
                    r.status = ST_DONE;
                else
                begin
                    if (!walk_started)
                    begin
                        for (k = 0; k < PICKS; k++)
                            combo_pos[k] = k;
                        walk_started = 1'b1;
                    end
                    for (k = 0; k < PICKS; k++)
                        r.picks[k] = combo_store[combo_pos[k]];
                    moved = 1'b0;
                    for (k = PICKS - 1; k >= 0 && !moved; k--)
                    begin
                        if (combo_pos[k] < set_size - PICKS + k)
                        begin
                            combo_pos[k]++;
                            for (j = k + 1; j < PICKS; j++)
                                combo_pos[j] = combo_pos[j-1] + 1;
                            moved = 1'b1;
                        end
                    end
                    if (!moved)
                    begin
                        walk_done   = 1'b1;
                        r.final_one = 1'b1;
                    end
                    r.status = overflowed ? ST_OVF : ST_OK;
                end
                pending_combos.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_bus.valid || req_taken)
            begin
                if (req_taken)
                begin
                    req_taken = 1'b0;
                    req_wait  = draw_wait();
                end
                if (req_wait > 0)
                begin
                    req_bus.valid <= 1'b0;
                    req_wait--;
                end
                else if (command_words.size() > 0)
                begin
                    next_word = command_words.pop_front();
                    req_bus.valid   <= 1'b1;
                    req_bus.command <= next_word.command;
                    req_bus.value   <= next_word.value;
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
            begin
                res_taken = 1'b0;
                res_wait  = draw_wait();
            end
            if (res_wait > 0)
            begin
                res_bus.ready <= 1'b0;
                res_wait--;
            end
            else
                res_bus.ready <= 1'b1;
        end
    end

    // A result word is checked before the request word of the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            idle_cycles++;
            if (res_bus.valid && res_bus.ready)
            begin
                idle_cycles = 0;
                res_taken   = 1'b1;
                if (pending_combos.size() == 0)
                begin
                    $error("result word with no request pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_combos.pop_front();
                    check_field("pick_a", want.picks[0], res_bus.pick_a);
                    check_field("pick_b", want.picks[1], res_bus.pick_b);
                    check_field("pick_c", want.picks[2], res_bus.pick_c);
                    check_field("pick_d", want.picks[3], res_bus.pick_d);
                    check_field("pick_e", want.picks[4], res_bus.pick_e);
                    check_field("pick_f", want.picks[5], res_bus.pick_f);
                    check_field("final_one", want.final_one, res_bus.final_one);
                    check_field("status", int'(want.status), int'(res_bus.status));
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                idle_cycles = 0;
                req_taken   = 1'b1;
                n_taken++;
                apply_command(req_bus.command, req_bus.value);
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int size;
        int asks;
        int r;
        int i;
        rst_n           = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.command = CMD_CLEAR;
        req_bus.value   = '0;
        res_bus.ready   = 1'b0;
        fail_count      = 0;
        n_total         = 0;
        n_counted       = 0;
        n_taken         = 0;
        cycle_count     = 0;
        idle_cycles     = 0;
        req_wait        = 0;
        res_wait        = 0;
        req_taken       = 1'b0;
        res_taken       = 1'b0;
        set_size        = 0;
        walk_started    = 1'b0;
        walk_done       = 1'b0;
        overflowed      = 1'b0;
        for (i = 0; i < PICKS; i++)
            combo_pos[i] = 0;

        // Directed: empty set, ignored command, extremes and duplicates, a restart
        // by a late load, the full walk of seven values, exhaustion and a clear.
        push_word(CMD_NEXT, 8'h00);
        push_word(CMD_UNUSED, 8'hAA);
        push_word(CMD_LOAD, 8'hFF);
        push_word(CMD_LOAD, 8'h00);
        push_word(CMD_LOAD, 8'h00);
        push_word(CMD_LOAD, 8'h80);
        push_word(CMD_LOAD, 8'h01);
        push_word(CMD_LOAD, 8'hFE);
        push_word(CMD_NEXT, 8'h55);
        push_word(CMD_LOAD, 8'h07);
        repeat (8)
            push_word(CMD_NEXT, 8'h00);
        push_word(CMD_CLEAR, 8'hFF);
        push_word(CMD_NEXT, 8'h00);

        while (n_counted < STIM_WORDS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                push_word(CMD_CLEAR, pick_value());
                r = $urandom_range(0, 19);
                if (r < 12)
                    size = $urandom_range(6, 9);
                else if (r < 16)
                    size = $urandom_range(0, 5);
                else if (r < 18)
                    size = $urandom_range(10, 16);
                else
                    size = $urandom_range(17, 20);
                repeat (size)
                    push_word(CMD_LOAD, pick_value());
                case (size)
                    6: asks = 1;
                    7: asks = 7;
                    8: asks = 28;
                    9: asks = 84;
                    default: asks = $urandom_range(1, 28);
                endcase
                asks += $urandom_range(0, 2);
                repeat (asks)
                begin
                    if ($urandom_range(0, 39) == 0)
                        push_word(CMD_LOAD, pick_value());
                    push_word(CMD_NEXT, value_t'($urandom_range(0, 255)));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    push_word(2'($urandom_range(0, 3)), value_t'($urandom_range(0, 255)));
            end
        end

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_taken < n_total)
            @(negedge clk);
        while (pending_combos.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT)
            @(negedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
